/* design/nfsa_pkg.sv */
// Package for the neighbour force scatter accumulator.
// Holds field widths, request codes and the controller/datapath command and status types.
// Depends on nothing.
`default_nettype none

package nfsa_pkg;

    localparam int ATOM_COUNT_DEF = 256;
    localparam int IDX_W          = 17;
    localparam int DATA_W         = 32;
    localparam int FORCE_W        = 48;
    localparam int FRAC_SHIFT     = 24;
    localparam int VEC_W          = 2 * DATA_W - FRAC_SHIFT;
    localparam int ROW_W          = 3 * FORCE_W;

    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_ACC   = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    typedef struct packed {
        logic latch;
        logic sweep;
        logic clr_wr;
        logic mul;
        logic rd_nbr;
        logic rd_ctr;
        logic wr_nbr;
        logic wr_ctr;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic [1:0] req;
        logic       ctr_ok;
        logic       nbr_ok;
        logic       out_full;
        logic       sweep_last;
        logic       sat_flag;
    } t_status;

endpackage

`default_nettype wire

/* design/nfsa_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Depends on nothing.
`default_nettype none

module nfsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* design/nfsa_ctrl.sv */
// Controller state machine of the neighbour force scatter accumulator.
// Depends on nfsa_pkg for the command and status types and the request codes.
`default_nettype none

module nfsa_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire nfsa_pkg::t_status i_status,
    output nfsa_pkg::t_cmd         o_cmd
);
    import nfsa_pkg::*;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_EXEC,
        S_NBR,
        S_CTR,
        S_READ
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.latch = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_status.req)
                    REQ_CLEAR: begin
                        o_cmd.clr_wr = i_status.ctr_ok;
                        n_state      = S_IDLE;
                    end
                    REQ_ACC: begin
                        if (i_status.ctr_ok && i_status.nbr_ok) begin
                            o_cmd.mul    = 1'b1;
                            o_cmd.rd_nbr = 1'b1;
                            n_state      = S_NBR;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    REQ_READ: begin
                        o_cmd.rd_ctr = i_status.ctr_ok;
                        n_state      = S_READ;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_NBR: begin
                o_cmd.wr_nbr = 1'b1;
                o_cmd.rd_ctr = 1'b1;
                n_state      = S_CTR;
            end
            S_CTR: begin
                o_cmd.wr_ctr = 1'b1;
                n_state      = S_IDLE;
            end
            S_READ: begin
                if (!i_status.out_full) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/nfsa_datapath.sv */
// Datapath of the neighbour force scatter accumulator: item registers, multipliers,
// saturating accumulate, force memory and output register.
// Depends on nfsa_pkg and nfsa_ram.
`default_nettype none

module nfsa_datapath #(
    parameter int ATOM_COUNT = nfsa_pkg::ATOM_COUNT_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire nfsa_pkg::t_cmd                       i_cmd,
    output nfsa_pkg::t_status                         o_status,
    input  wire logic [1:0]                           i_req_type,
    input  wire logic [7:0]                           i_center_atom,
    input  wire logic signed [8:0]                    i_neighbor_atom,
    input  wire logic signed [nfsa_pkg::DATA_W-1:0]   i_net_derivative,
    input  wire logic signed [nfsa_pkg::DATA_W-1:0]   i_env_x,
    input  wire logic signed [nfsa_pkg::DATA_W-1:0]   i_env_y,
    input  wire logic signed [nfsa_pkg::DATA_W-1:0]   i_env_z,
    input  wire logic                                 i_out_ready,
    output logic                                      o_out_valid,
    output logic [7:0]                                o_atom_read,
    output logic signed [nfsa_pkg::FORCE_W-1:0]       o_force_out_x,
    output logic signed [nfsa_pkg::FORCE_W-1:0]       o_force_out_y,
    output logic signed [nfsa_pkg::FORCE_W-1:0]       o_force_out_z,
    output logic                                      o_overflow_seen
);
    import nfsa_pkg::*;

    localparam int AW = $clog2(ATOM_COUNT);
    localparam logic [AW-1:0]    LAST_ADDR = AW'(ATOM_COUNT - 1);
    localparam logic [IDX_W-1:0] COUNT_IDX = IDX_W'(ATOM_COUNT);
    localparam logic signed [FORCE_W-1:0] ACC_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
    localparam logic signed [FORCE_W-1:0] ACC_MIN = {1'b1, {(FORCE_W-1){1'b0}}};

    // Returns the overflow flag above the saturated sum or difference.
    function automatic logic [FORCE_W:0] sat_add(
        input logic signed [FORCE_W-1:0] a,
        input logic signed [VEC_W-1:0]   v,
        input logic                      neg
    );
        logic signed [FORCE_W+1:0] s;
        logic signed [FORCE_W+1:0] b;
        logic [FORCE_W:0]          r;
        b = (FORCE_W+2)'(v);
        s = neg ? ((FORCE_W+2)'(a) - b) : ((FORCE_W+2)'(a) + b);
        if ((s[FORCE_W+1] == s[FORCE_W]) && (s[FORCE_W] == s[FORCE_W-1])) begin
            r = {1'b0, s[FORCE_W-1:0]};
        end else if (s[FORCE_W+1]) begin
            r = {1'b1, ACC_MIN};
        end else begin
            r = {1'b1, ACC_MAX};
        end
        return r;
    endfunction

    logic [1:0]               r_req;
    logic [7:0]               r_ctr;
    logic signed [8:0]        r_nbr;
    logic signed [DATA_W-1:0] r_nd;
    logic signed [DATA_W-1:0] r_ex;
    logic signed [DATA_W-1:0] r_ey;
    logic signed [DATA_W-1:0] r_ez;
    logic signed [VEC_W-1:0]  r_vx;
    logic signed [VEC_W-1:0]  r_vy;
    logic signed [VEC_W-1:0]  r_vz;
    logic [ROW_W-1:0]         r_fwd;
    logic [AW-1:0]            r_sweep;
    logic                     r_sat;

    logic signed [2*DATA_W-1:0] px;
    logic signed [2*DATA_W-1:0] py;
    logic signed [2*DATA_W-1:0] pz;
    logic [IDX_W-1:0]           ctr_idx;
    logic [IDX_W-1:0]           nbr_idx;
    logic [AW-1:0]              ctr_addr;
    logic [AW-1:0]              nbr_addr;
    logic                       same;
    logic [ROW_W-1:0]           rdata;
    logic [ROW_W-1:0]           src;
    logic [FORCE_W:0]           sx;
    logic [FORCE_W:0]           sy;
    logic [FORCE_W:0]           sz;
    logic [ROW_W-1:0]           new_row;
    logic                       sat_hit;
    logic                       we;
    logic [AW-1:0]              waddr;
    logic [ROW_W-1:0]           wdata;
    logic                       re;
    logic [AW-1:0]              raddr;

    assign ctr_idx  = IDX_W'(r_ctr);
    assign nbr_idx  = IDX_W'(r_nbr[7:0]);
    assign ctr_addr = ctr_idx[AW-1:0];
    assign nbr_addr = nbr_idx[AW-1:0];
    assign same     = (r_nbr[7:0] == r_ctr);

    assign px = (2*DATA_W)'(r_nd) * (2*DATA_W)'(r_ex);
    assign py = (2*DATA_W)'(r_nd) * (2*DATA_W)'(r_ey);
    assign pz = (2*DATA_W)'(r_nd) * (2*DATA_W)'(r_ez);

    assign src = i_cmd.wr_ctr && same ? r_fwd : rdata;
    assign sx  = sat_add(src[3*FORCE_W-1:2*FORCE_W], r_vx, i_cmd.wr_ctr);
    assign sy  = sat_add(src[2*FORCE_W-1:FORCE_W], r_vy, i_cmd.wr_ctr);
    assign sz  = sat_add(src[FORCE_W-1:0], r_vz, i_cmd.wr_ctr);
    assign new_row = {sx[FORCE_W-1:0], sy[FORCE_W-1:0], sz[FORCE_W-1:0]};
    assign sat_hit = sx[FORCE_W] | sy[FORCE_W] | sz[FORCE_W];

    always_comb begin
        we    = i_cmd.sweep | i_cmd.clr_wr | i_cmd.wr_nbr | i_cmd.wr_ctr;
        waddr = ctr_addr;
        wdata = '0;
        if (i_cmd.sweep) begin
            waddr = r_sweep;
        end else if (i_cmd.wr_nbr) begin
            waddr = nbr_addr;
            wdata = new_row;
        end else if (i_cmd.wr_ctr) begin
            wdata = new_row;
        end
        re    = i_cmd.rd_nbr | i_cmd.rd_ctr;
        raddr = i_cmd.rd_nbr ? nbr_addr : ctr_addr;
    end

    nfsa_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ATOM_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req <= i_req_type;
            r_ctr <= i_center_atom;
            r_nbr <= i_neighbor_atom;
            r_nd  <= i_net_derivative;
            r_ex  <= i_env_x;
            r_ey  <= i_env_y;
            r_ez  <= i_env_z;
        end
        if (i_cmd.mul) begin
            r_vx <= px[2*DATA_W-1:FRAC_SHIFT];
            r_vy <= py[2*DATA_W-1:FRAC_SHIFT];
            r_vz <= pz[2*DATA_W-1:FRAC_SHIFT];
        end
        if (i_cmd.wr_nbr) begin
            r_fwd <= new_row;
        end
        if (i_cmd.load_out) begin
            o_atom_read     <= r_ctr;
            o_force_out_x   <= o_status.ctr_ok ? rdata[3*FORCE_W-1:2*FORCE_W] : '0;
            o_force_out_y   <= o_status.ctr_ok ? rdata[2*FORCE_W-1:FORCE_W] : '0;
            o_force_out_z   <= o_status.ctr_ok ? rdata[FORCE_W-1:0] : '0;
            o_overflow_seen <= r_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep     <= '0;
            r_sat       <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cmd.sweep) begin
                r_sweep <= r_sweep + AW'(1);
            end
            if ((i_cmd.wr_nbr || i_cmd.wr_ctr) && sat_hit) begin
                r_sat <= 1'b1;
            end
            if (i_cmd.load_out) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.req        = r_req;
    assign o_status.ctr_ok     = (ctr_idx < COUNT_IDX);
    assign o_status.nbr_ok     = !r_nbr[8] && (nbr_idx < COUNT_IDX);
    assign o_status.out_full   = o_out_valid;
    assign o_status.sweep_last = (r_sweep == LAST_ADDR);
    assign o_status.sat_flag   = r_sat;

endmodule

`default_nettype wire

/* design/neighbor_force_scatter_accumulate_top.sv */
// Top level of the neighbour force scatter accumulator.
// Depends on nfsa_pkg, nfsa_ctrl, nfsa_datapath and nfsa_ram.
//
// Items arrive on the input channel (i_in_valid, o_in_ready); each one clears
// one atom's force entry, accumulates into a neighbour and a centre entry, or
// reads one atom's entry. Only a read gives a result item, on the output channel
// (o_out_valid, i_out_ready). For an accumulate item the product vector is
// formed, then the neighbour entry and the centre entry each get one
// read-modify-write on the single force memory, before the next item is taken.
// A clear or ignored item is done in the execute state. A read item reads the
// centre entry, then loads its result in the read state; the result shows and
// the input is freed together. The result sits in an output register, so
// further items are taken while it waits; a second read waits for the receiver
// only when it must load its own result into that register.
// After reset the block zeroes the force memory, one entry per cycle, from
// entry 0 to entry ATOM_COUNT-1, and holds o_in_ready low meanwhile. The sticky
// overflow flag clears at reset.
`default_nettype none

module neighbor_force_scatter_accumulate_top #(
    parameter int ATOM_COUNT = nfsa_pkg::ATOM_COUNT_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [1:0]                         i_req_type,
    input  wire logic [7:0]                         i_center_atom,
    input  wire logic signed [8:0]                  i_neighbor_atom,
    input  wire logic signed [nfsa_pkg::DATA_W-1:0] i_net_derivative,
    input  wire logic signed [nfsa_pkg::DATA_W-1:0] i_env_x,
    input  wire logic signed [nfsa_pkg::DATA_W-1:0] i_env_y,
    input  wire logic signed [nfsa_pkg::DATA_W-1:0] i_env_z,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [7:0]                              o_atom_read,
    output logic signed [nfsa_pkg::FORCE_W-1:0]     o_force_out_x,
    output logic signed [nfsa_pkg::FORCE_W-1:0]     o_force_out_y,
    output logic signed [nfsa_pkg::FORCE_W-1:0]     o_force_out_z,
    output logic                                    o_overflow_seen
);
    import nfsa_pkg::*;

    t_cmd    cmd;
    t_status status;

    nfsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    nfsa_datapath #(
        .ATOM_COUNT (ATOM_COUNT)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_req_type       (i_req_type),
        .i_center_atom    (i_center_atom),
        .i_neighbor_atom  (i_neighbor_atom),
        .i_net_derivative (i_net_derivative),
        .i_env_x          (i_env_x),
        .i_env_y          (i_env_y),
        .i_env_z          (i_env_z),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_atom_read      (o_atom_read),
        .o_force_out_x    (o_force_out_x),
        .o_force_out_y    (o_force_out_y),
        .o_force_out_z    (o_force_out_z),
        .o_overflow_seen  (o_overflow_seen)
    );

    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.sweep, cmd.clr_wr, cmd.wr_nbr, cmd.wr_ctr}))
        else $error("More than one writer of the force memory in one cycle.");

    a_no_item_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.sweep |-> !o_in_ready)
        else $error("Input ready while the force memory is being cleared.");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> !o_out_valid)
        else $error("Read result loaded over a result not yet taken.");

    a_sticky_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.sat_flag |=> status.sat_flag)
        else $error("Overflow flag cleared outside reset.");

    a_centre_after_nbr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.wr_nbr |=> cmd.wr_ctr)
        else $error("Neighbour update not followed by the centre update.");

endmodule

`default_nettype wire
